FILE: src/grhp_pkg.sv
`default_nettype none

package grhp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    localparam logic [3:0] K_NONE          = 4'd0;
    localparam logic [3:0] K_META          = 4'd1;
    localparam logic [3:0] K_BODY          = 4'd2;
    localparam logic [3:0] K_INPUT         = 4'd3;
    localparam logic [3:0] K_SENSITIVE     = 4'd4;
    localparam logic [3:0] K_SUCCESS       = 4'd5;
    localparam logic [3:0] K_REDIRECT      = 4'd6;
    localparam logic [3:0] K_PERM_REDIRECT = 4'd7;
    localparam logic [3:0] K_ERROR         = 4'd8;
    localparam logic [3:0] K_CERT          = 4'd9;

    localparam logic [2:0] EC_UNKNOWN      = 3'd0;
    localparam logic [2:0] EC_PROTOCOL     = 3'd1;
    localparam logic [2:0] EC_SERVER       = 3'd2;
    localparam logic [2:0] EC_NOT_FOUND    = 3'd3;
    localparam logic [2:0] EC_PROXY        = 3'd4;
    localparam logic [2:0] EC_BAD_REQUEST  = 3'd5;
    localparam logic [2:0] EC_UNAUTHORIZED = 3'd6;
    localparam logic [2:0] EC_BAD_CERT     = 3'd7;

    localparam logic [2:0] VR_SHORT  = 3'd0;
    localparam logic [2:0] VR_LARGE  = 3'd1;
    localparam logic [2:0] VR_NO_CR  = 3'd2;
    localparam logic [2:0] VR_FIRST  = 3'd3;
    localparam logic [2:0] VR_SECOND = 3'd4;
    localparam logic [2:0] VR_THIRD  = 3'd5;
    localparam logic [2:0] VR_STATUS = 3'd6;

    localparam logic [10:0] MAX_LEN_RST = 11'd1200;
    localparam logic [10:0] MIN_LEN     = 11'd4;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] error_class;
        logic [2:0] violation_reason;
        logic       to_body;
    } verdict_t;

endpackage

`default_nettype wire

FILE: src/grhp_verdict.sv
`default_nettype none

module grhp_verdict (
    input  wire logic [10:0]       header_count,
    input  wire logic [10:0]       max_header_len,
    input  wire logic [7:0]        held_char,
    input  wire logic [7:0]        first_char,
    input  wire logic [7:0]        second_char,
    input  wire logic [7:0]        third_char,
    output grhp_pkg::verdict_t     verdict
);

    logic       first_digit;
    logic       second_digit;
    logic       third_ws;
    logic [3:0] p;
    logic [3:0] s;
    logic [7:0] p_full;
    logic [7:0] s_full;

    assign first_digit  = (first_char >= grhp_pkg::CH_ZERO) && (first_char <= grhp_pkg::CH_NINE);
    assign second_digit = (second_char >= grhp_pkg::CH_ZERO)
                       && (second_char <= grhp_pkg::CH_NINE);
    assign third_ws     = (third_char == grhp_pkg::CH_SP)
                       || ((third_char >= grhp_pkg::CH_TAB) && (third_char <= grhp_pkg::CH_CR));
    assign p_full = first_char - grhp_pkg::CH_ZERO;
    assign s_full = second_char - grhp_pkg::CH_ZERO;
    assign p      = p_full[3:0];
    assign s      = s_full[3:0];

    always_comb begin
        verdict.kind             = grhp_pkg::K_ERROR;
        verdict.error_class      = grhp_pkg::EC_PROTOCOL;
        verdict.violation_reason = grhp_pkg::VR_SHORT;
        verdict.to_body          = 1'b0;
        if (header_count < grhp_pkg::MIN_LEN) begin
            verdict.violation_reason = grhp_pkg::VR_SHORT;
        end else if (header_count >= max_header_len) begin
            verdict.violation_reason = grhp_pkg::VR_LARGE;
        end else if (held_char != grhp_pkg::CH_CR) begin
            verdict.violation_reason = grhp_pkg::VR_NO_CR;
        end else if (!first_digit) begin
            verdict.violation_reason = grhp_pkg::VR_FIRST;
        end else if (!second_digit) begin
            verdict.violation_reason = grhp_pkg::VR_SECOND;
        end else if (!third_ws) begin
            verdict.violation_reason = grhp_pkg::VR_THIRD;
        end else begin
            verdict.error_class      = grhp_pkg::EC_UNKNOWN;
            verdict.violation_reason = grhp_pkg::VR_SHORT;
            unique case (p)
                4'd1: begin
                    verdict.kind = (s == 4'd1) ? grhp_pkg::K_SENSITIVE : grhp_pkg::K_INPUT;
                end
                4'd2: begin
                    verdict.kind    = grhp_pkg::K_SUCCESS;
                    verdict.to_body = 1'b1;
                end
                4'd3: begin
                    verdict.kind = (s == 4'd1) ? grhp_pkg::K_PERM_REDIRECT
                                               : grhp_pkg::K_REDIRECT;
                end
                4'd4: begin
                    verdict.error_class = (s >= 4'd1 && s <= 4'd3) ? grhp_pkg::EC_SERVER
                                                                   : grhp_pkg::EC_UNKNOWN;
                end
                4'd5: begin
                    case (s)
                        4'd1, 4'd2: verdict.error_class = grhp_pkg::EC_NOT_FOUND;
                        4'd3:       verdict.error_class = grhp_pkg::EC_PROXY;
                        4'd9:       verdict.error_class = grhp_pkg::EC_BAD_REQUEST;
                        default:    verdict.error_class = grhp_pkg::EC_UNKNOWN;
                    endcase
                end
                4'd6: begin
                    if (s == 4'd0) begin
                        verdict.kind = grhp_pkg::K_CERT;
                    end else if (s == 4'd1) begin
                        verdict.error_class = grhp_pkg::EC_UNAUTHORIZED;
                    end else begin
                        verdict.error_class = grhp_pkg::EC_BAD_CERT;
                    end
                end
                default: begin
                    // status digit 0, 7, 8 or 9
                    verdict.error_class      = grhp_pkg::EC_PROTOCOL;
                    verdict.violation_reason = grhp_pkg::VR_STATUS;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/gemini_response_header_parser_core.sv
`default_nettype none

// response header parser for one request stream, one byte per request.
// input channel: s_valid/s_ready with s_op (0 data byte, 1 start new request)
//   and s_data_byte. output channel: m_valid/m_ready with m_kind, m_out_byte,
//   m_error_class, m_violation_reason; every input request yields exactly
//   one result.
// latency: a result is presented the cycle after its request is accepted.
// throughput: one request per cycle; the single output register is refilled
//   in the same cycle it is taken, so s_ready = !m_valid || m_ready.
// when the receiver stalls, the result is held and s_ready drops until it
//   is taken; no request is lost.
// cfg_wr_en/cfg_wr_data write the header length limit (11 bits), applied
//   from the next accepted request on. write it only while idle.
// reset (aresetn low, synchronous): the limit returns to 1200, the parser
//   returns to the header phase and the output register is emptied.
// meta bytes come out one request late; at LF a verdict is reported.
// success switches to body pass-through; every other verdict ends the
//   response until a start request.
module gemini_response_header_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_kind,
    output logic [7:0]       m_out_byte,
    output logic [2:0]       m_error_class,
    output logic [2:0]       m_violation_reason
);

    grhp_pkg::phase_t   phase_reg, phase_next;
    logic [10:0]        count_reg, count_next;
    logic [7:0]         first_reg, first_next;
    logic [7:0]         second_reg, second_next;
    logic [7:0]         third_reg, third_next;
    logic [7:0]         held_reg, held_next;
    logic [10:0]        max_len_reg;

    logic               m_valid_reg, m_valid_next;
    logic [3:0]         kind_reg, kind_next;
    logic [7:0]         byte_reg, byte_next;
    logic [2:0]         ec_reg, ec_next;
    logic [2:0]         vr_reg, vr_next;

    logic               s_fire;
    logic [11:0]        count_inc;
    grhp_pkg::verdict_t verdict;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign count_inc = {1'b0, count_reg} + 12'd1;

    grhp_verdict u_verdict (
        .header_count   (count_reg),
        .max_header_len (max_len_reg),
        .held_char      (held_reg),
        .first_char     (first_reg),
        .second_char    (second_reg),
        .third_char     (third_reg),
        .verdict        (verdict)
    );

    // parser state
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        held_next   = held_reg;
        if (s_fire) begin
            if (s_op == grhp_pkg::OP_START) begin
                phase_next  = grhp_pkg::PH_HEADER;
                count_next  = '0;
                first_next  = '0;
                second_next = '0;
                third_next  = '0;
                held_next   = '0;
            end else if (phase_reg == grhp_pkg::PH_HEADER) begin
                if (s_data_byte == grhp_pkg::CH_LF) begin
                    phase_next = verdict.to_body ? grhp_pkg::PH_BODY : grhp_pkg::PH_DONE;
                end else if (count_inc >= {1'b0, max_len_reg}) begin
                    phase_next = grhp_pkg::PH_DONE;
                end else begin
                    if (count_reg == 11'd0) first_next  = s_data_byte;
                    if (count_reg == 11'd1) second_next = s_data_byte;
                    if (count_reg == 11'd2) third_next  = s_data_byte;
                    held_next  = s_data_byte;
                    count_next = count_inc[10:0];
                end
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        ec_next      = ec_reg;
        vr_next      = vr_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            m_valid_next = 1'b1;
            kind_next    = grhp_pkg::K_NONE;
            byte_next    = '0;
            ec_next      = grhp_pkg::EC_UNKNOWN;
            vr_next      = grhp_pkg::VR_SHORT;
            if (s_op == grhp_pkg::OP_DATA) begin
                unique case (phase_reg)
                    grhp_pkg::PH_BODY: begin
                        kind_next = grhp_pkg::K_BODY;
                        byte_next = s_data_byte;
                    end
                    grhp_pkg::PH_HEADER: begin
                        if (s_data_byte == grhp_pkg::CH_LF) begin
                            kind_next = verdict.kind;
                            ec_next   = verdict.error_class;
                            vr_next   = verdict.violation_reason;
                        end else if (count_inc >= {1'b0, max_len_reg}) begin
                            kind_next = grhp_pkg::K_ERROR;
                            ec_next   = grhp_pkg::EC_PROTOCOL;
                            vr_next   = grhp_pkg::VR_LARGE;
                        end else if (count_reg >= grhp_pkg::MIN_LEN) begin
                            kind_next = grhp_pkg::K_META;
                            byte_next = held_reg;
                        end
                    end
                    default: begin
                        kind_next = grhp_pkg::K_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= grhp_pkg::PH_HEADER;
            count_reg   <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            third_reg   <= '0;
            held_reg    <= '0;
            max_len_reg <= grhp_pkg::MAX_LEN_RST;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            third_reg   <= third_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        ec_reg   <= ec_next;
        vr_reg   <= vr_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = kind_reg;
    assign m_out_byte         = byte_reg;
    assign m_error_class      = ec_reg;
    assign m_violation_reason = vr_reg;

`ifndef NO_ASSERTIONS
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted request produced no result");

    a_done_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_op == grhp_pkg::OP_DATA) && (phase_reg == grhp_pkg::PH_DONE)
        |=> (m_kind == grhp_pkg::K_NONE))
        else $error("byte after terminal verdict produced output");

    a_byte_only_with_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != grhp_pkg::K_META) && (m_kind != grhp_pkg::K_BODY)
        |-> (m_out_byte == 8'd0))
        else $error("out byte set on non-data result");

    a_reason_only_protocol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_violation_reason != grhp_pkg::VR_SHORT)
        |-> (m_kind == grhp_pkg::K_ERROR) && (m_error_class == grhp_pkg::EC_PROTOCOL))
        else $error("violation reason without protocol error");

    a_body_after_success: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == grhp_pkg::PH_BODY) && ($past(phase_reg) == grhp_pkg::PH_HEADER)
        |-> (m_kind == grhp_pkg::K_SUCCESS))
        else $error("body phase entered without success verdict");
`endif

endmodule

`default_nettype wire
